### hdl/lsie_pkg.sv
`timescale 1ns / 1ps

package lsie_pkg;

    // Distribution constants
    localparam int LAP_TOTAL      = 32768;
    localparam int LAP_HALF       = 16384;
    localparam int LAP_QBITS      = 15;
    localparam int LAP_TAIL_PAIRS = 16;
    localparam int LAP_FT_BASE    = LAP_TOTAL - 2 * LAP_TAIL_PAIRS;

    // Field widths
    localparam int SYM_W   = 16;
    localparam int PROB_W  = 15;
    localparam int DECAY_W = 14;
    localparam int IVL_W   = 16;

    // Shared multiplier operand widths
    localparam int MUL_A_W = 16;
    localparam int MUL_B_W = 15;
    localparam int MUL_Q_W = 16;

    // Stream payload widths, padded to whole bytes
    localparam int IN_DATA_W  = ((SYM_W + PROB_W + DECAY_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((IVL_W + IVL_W + SYM_W + 7) / 8) * 8;

endpackage

### hdl/lsie_mul_unit.sv
`timescale 1ns / 1ps

// Shared Q15 multiply: q = (a * b) >> 15, caller registers q.
module lsie_mul_unit
    import lsie_pkg::*;
(
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic [MUL_Q_W-1:0] q
);

    logic [MUL_A_W+MUL_B_W-1:0] prod;

    assign prod = MUL_A_W'(a) * MUL_B_W'(b);
    assign q    = prod[LAP_QBITS +: MUL_Q_W];

endmodule

### hdl/laplace_symbol_interval_encoder_top.sv
`timescale 1ns / 1ps

// Channel  | Dir | Signals                       | Payload
// ---------+-----+-------------------------------+---------------------------------
// s_       | in  | s_tvalid s_tready s_tdata[47:0] | symbol, zero prob, decay
// m_       | out | m_tvalid m_tready m_tdata[47:0] | interval low/high, coded value
//
// One request at a time. A zero symbol goes from accept straight to result. A nonzero
// symbol passes accept, init, its N band steps and the in-band exit before result, or
// in the tail the exit, clamp and adjust before result. N is set by the band loop
// through the single shared Q15 multiplier: at most |symbol|-1, and with decay near
// 16384 the slot shrinks by about one unit a step.
// rst_n is asynchronous, active low, and clears the sequencer and output valid.
// A result held in the output register does not block the next request; only
// the final load waits while m_tready is low.
module laplace_symbol_interval_encoder_top
    import lsie_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [15:0] symbol_value, [30:16] zero_probability, [44:31] decay_rate, rest zero
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [15:0] interval_low, [31:16] interval_high, [47:32] coded_value
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int FL_W  = 18;
    localparam int MAG_W = SYM_W + 1;

    localparam logic signed [FL_W-1:0] TOTAL_S    = FL_W'(LAP_TOTAL);
    localparam logic [MUL_A_W-1:0]     FT_BASE_W  = MUL_A_W'(LAP_FT_BASE);
    localparam logic [MUL_B_W-1:0]     HALF_W     = MUL_B_W'(LAP_HALF);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_LOOP,
        ST_TAIL,
        ST_TAIL_ADJ,
        ST_RESULT
    } state_t;

    state_t                   state_reg;
    logic signed [FL_W-1:0]   fl_reg;      // running cumulative low
    logic [IVL_W-1:0]         fs_reg;      // current slot size
    logic [MAG_W-1:0]         mag_reg;
    logic [MAG_W-1:0]         i_reg;       // current magnitude step
    logic                     neg_reg;
    logic [PROB_W-1:0]        fs0_reg;
    logic [DECAY_W-1:0]       decay_reg;
    logic [SYM_W-1:0]         coded_reg;
    logic signed [FL_W-1:0]   di_reg;      // clamped tail offset
    logic                     m_tvalid_reg;
    logic [OUT_DATA_W-1:0]    m_tdata_reg;

    // input unpack
    logic [SYM_W-1:0]   in_sym;
    logic [PROB_W-1:0]  in_fs0;
    logic [DECAY_W-1:0] in_decay;
    logic               in_neg;
    logic [MAG_W-1:0]   in_mag;

    assign in_sym   = s_tdata[SYM_W-1:0];
    assign in_fs0   = s_tdata[SYM_W +: PROB_W];
    assign in_decay = s_tdata[SYM_W+PROB_W +: DECAY_W];
    assign in_neg   = in_sym[SYM_W-1];
    assign in_mag   = in_neg ? (MAG_W'(0) - {in_sym[SYM_W-1], in_sym}) : {1'b0, in_sym};

    // shared multiplier operands
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_Q_W-1:0] mul_q;

    always_comb
    begin
        if (state_reg == ST_INIT)
        begin
            // first slot: saturated (total - tail - fs0) * (half - decay)
            mul_a = ({1'b0, fs0_reg} > FT_BASE_W) ? '0 : (FT_BASE_W - {1'b0, fs0_reg});
            mul_b = HALF_W - {1'b0, decay_reg};
        end
        else
        begin
            // band step: (2 * fs) * decay
            mul_a = {fs_reg[MUL_A_W-2:0], 1'b0};
            mul_b = {1'b0, decay_reg};
        end
    end

    lsie_mul_unit u_mul (
        .a (mul_a),
        .b (mul_b),
        .q (mul_q)
    );

    // tail clamp terms
    logic signed [FL_W-1:0] room;
    logic signed [FL_W-1:0] ndi_lim;
    logic signed [FL_W-1:0] di_raw;
    logic signed [FL_W-1:0] fl_tail;
    logic signed [FL_W-1:0] m_tail;
    logic signed [FL_W-1:0] m_coded;
    logic signed [FL_W-1:0] fl_plus_fs;

    always_comb
    begin
        room       = TOTAL_S - fl_reg + $signed({{(FL_W-1){1'b0}}, neg_reg});
        ndi_lim    = (room >>> 1) - FL_W'(1);
        di_raw     = $signed({1'b0, mag_reg}) - $signed({1'b0, i_reg});
        fl_tail    = fl_reg + (di_reg <<< 1) + FL_W'(1)
                     - $signed({{(FL_W-1){1'b0}}, neg_reg});
        m_tail     = $signed({1'b0, i_reg}) + di_reg;
        m_coded    = neg_reg ? (FL_W'(0) - m_tail) : m_tail;
        fl_plus_fs = fl_reg + $signed({{(FL_W-IVL_W){1'b0}}, fs_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            fl_reg       <= '0;
            fs_reg       <= '0;
            mag_reg      <= '0;
            i_reg        <= '0;
            neg_reg      <= 1'b0;
            fs0_reg      <= '0;
            decay_reg    <= '0;
            coded_reg    <= '0;
            di_reg       <= '0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            // output valid: set on a result load, cleared when taken
            if (state_reg == ST_RESULT && (!m_tvalid_reg || m_tready))
                m_tvalid_reg <= 1'b1;
            else if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        fs0_reg   <= in_fs0;
                        decay_reg <= in_decay;
                        neg_reg   <= in_neg;
                        mag_reg   <= in_mag;
                        coded_reg <= in_sym;
                        i_reg     <= MAG_W'(1);
                        if (in_sym == '0)
                        begin
                            fl_reg    <= '0;
                            fs_reg    <= {1'b0, in_fs0};
                            state_reg <= ST_RESULT;
                        end
                        else
                        begin
                            fl_reg    <= $signed({{(FL_W-PROB_W){1'b0}}, in_fs0});
                            state_reg <= ST_INIT;
                        end
                    end
                end

                ST_INIT:
                begin
                    fs_reg    <= mul_q;
                    state_reg <= ST_LOOP;
                end

                ST_LOOP:
                begin
                    if (fs_reg != '0 && i_reg < mag_reg)
                    begin
                        fl_reg <= fl_reg + $signed({{(FL_W-IVL_W-1){1'b0}}, fs_reg, 1'b0})
                                  + FL_W'(2);
                        fs_reg <= mul_q;
                        i_reg  <= i_reg + MAG_W'(1);
                    end
                    else if (fs_reg == '0)
                    begin
                        state_reg <= ST_TAIL;
                    end
                    else
                    begin
                        // in band: one extra unit, positive side sits above negative
                        fs_reg <= fs_reg + IVL_W'(1);
                        if (!neg_reg)
                            fl_reg <= fl_plus_fs + FL_W'(1);
                        state_reg <= ST_RESULT;
                    end
                end

                ST_TAIL:
                begin
                    di_reg    <= (di_raw > ndi_lim) ? ndi_lim : di_raw;
                    state_reg <= ST_TAIL_ADJ;
                end

                ST_TAIL_ADJ:
                begin
                    fl_reg    <= fl_tail;
                    fs_reg    <= (fl_tail == TOTAL_S) ? IVL_W'(0) : IVL_W'(1);
                    coded_reg <= m_coded[SYM_W-1:0];
                    state_reg <= ST_RESULT;
                end

                ST_RESULT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tdata_reg  <= {coded_reg, fl_plus_fs[IVL_W-1:0],
                                         fl_reg[IVL_W-1:0]};
                        state_reg    <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### hdl/lsie_checker.sv
`timescale 1ns / 1ps

module lsie_checker
    import lsie_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [IN_DATA_W-1:0]  s_tdata,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // held result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // held result payload does not change
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result payload changed while stalled");

    // one request in work at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // interval is ordered and inside the total
    a_interval: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[31:16] >= m_tdata[15:0])
                     && (m_tdata[31:16] <= 16'(LAP_TOTAL)))
        else $error("bad interval bounds");

    // reset leaves no result pending by the next edge
    a_reset: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result valid during reset");

endmodule

bind laplace_symbol_interval_encoder_top lsie_checker u_lsie_checker (.*);
